// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Wrappers for concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is asserted
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions of the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NO_QUOTE   = 3'd0;
	localparam logic [2:0] ERR_UNTERM     = 3'd1;
	localparam logic [2:0] ERR_ESC_CUT    = 3'd2;
	localparam logic [2:0] ERR_UNI_CUT    = 3'd3;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd4;
	localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd5;

	// Most results one transaction can cause
	localparam int MAX_RES = 4;

	// One result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] code;
	} res_t;

	// Results of one input transaction, handed from decode to the output buffer
	typedef struct packed {
		logic [2:0]              cnt;
		res_t [MAX_RES-1:0]      r;
	} burst_t;

	// UTF-8 encoding of one code point
	typedef struct packed {
		logic [2:0]       len;
		logic [3:0][7:0]  b;
	} utf8_t;

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t u;
		u.len = 3'd0;
		u.b   = '0;
		if (cp < 21'h80) begin
			u.len  = 3'd1;
			u.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			u.len  = 3'd2;
			u.b[0] = {3'b110, cp[10:6]};
			u.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			u.len  = 3'd3;
			u.b[0] = {4'b1110, cp[15:12]};
			u.b[1] = {2'b10, cp[11:6]};
			u.b[2] = {2'b10, cp[5:0]};
		end else begin
			u.len  = 3'd4;
			u.b[0] = {5'b11110, cp[20:18]};
			u.b[1] = {2'b10, cp[17:12]};
			u.b[2] = {2'b10, cp[11:6]};
			u.b[3] = {2'b10, cp[5:0]};
		end
		return u;
	endfunction

	// Hex digit value; bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			v = {1'b1, b[3:0] + 4'd9};
		end
		return v;
	endfunction

	// Simple escape letters; bit 8 set when the letter is one of them
	function automatic logic [8:0] escape_map(input logic [7:0] b);
		logic [8:0] m;
		case (b)
			8'h22:   m = {1'b1, 8'h22};
			8'h5C:   m = {1'b1, 8'h5C};
			8'h2F:   m = {1'b1, 8'h2F};
			8'h62:   m = {1'b1, 8'h08};
			8'h66:   m = {1'b1, 8'h0C};
			8'h6E:   m = {1'b1, 8'h0A};
			8'h72:   m = {1'b1, 8'h0D};
			8'h74:   m = {1'b1, 8'h09};
			default: m = 9'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// String state and per-byte decode: turns one input transaction into up to
// four results and the next state, committed when the transaction advances.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,    // item in the input register is consumed
	input  logic       mode,       // 1 = end of text
	input  logic [7:0] text_byte,
	output burst_t     burst
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STR,
		PH_ESC,
		PH_HEX,
		PH_HIGH,
		PH_HIGH_BS,
		PH_LOW,
		PH_SKIP
	} phase_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	phase_t      phase_q, phase_n;
	logic [15:0] acc_q, acc_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [15:0] held_q, held_n;

	logic        is_quote, is_bs, is_u;
	logic [4:0]  hv;
	logic [8:0]  em;
	logic [15:0] acc_sh;
	logic        hi_sur, lo_sur;
	logic [20:0] pair_cp;

	logic        u_en;
	logic [20:0] u_cp;
	logic        t_en;
	logic [1:0]  t_kind;
	logic [7:0]  t_data;
	logic [2:0]  t_code;
	logic        do_str, do_esc, do_fail;
	logic [2:0]  f_code;
	utf8_t       enc;
	logic [2:0]  u_len;

	// Byte classification and hex accumulation
	assign is_quote = !mode && (text_byte == CH_QUOTE);
	assign is_bs    = !mode && (text_byte == CH_BSLASH);
	assign is_u     = !mode && (text_byte == CH_U);
	assign hv       = hex_value(text_byte);
	assign em       = escape_map(text_byte);
	assign acc_sh   = {acc_q[11:0], hv[3:0]};
	assign hi_sur   = (acc_sh[15:10] == 6'b110110);
	assign lo_sur   = (acc_sh[15:10] == 6'b110111);
	assign pair_cp  = 21'h10000 + {1'b0, held_q[9:0], acc_sh[9:0]};

	// Next state and result selection
	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		held_n  = held_q;
		u_en    = 1'b0;
		u_cp    = '0;
		t_en    = 1'b0;
		t_kind  = KIND_BYTE;
		t_data  = '0;
		t_code  = '0;
		do_str  = 1'b0;
		do_esc  = 1'b0;
		do_fail = 1'b0;
		f_code  = ERR_NO_QUOTE;

		case (phase_q)
			PH_IDLE: begin
				if (is_quote) begin
					phase_n = PH_STR;
					acc_n   = '0;
					cnt_n   = '0;
					held_n  = '0;
				end else begin
					do_fail = 1'b1;
					f_code  = ERR_NO_QUOTE;
				end
			end
			PH_SKIP: begin
				if (is_quote) begin
					phase_n = PH_STR;
					acc_n   = '0;
					cnt_n   = '0;
					held_n  = '0;
				end
			end
			PH_STR: begin
				if (mode) begin
					do_fail = 1'b1;
					f_code  = ERR_UNTERM;
				end else begin
					do_str = 1'b1;
				end
			end
			PH_ESC: begin
				if (mode) begin
					do_fail = 1'b1;
					f_code  = ERR_ESC_CUT;
				end else begin
					do_esc = 1'b1;
				end
			end
			PH_HEX: begin
				if (mode) begin
					do_fail = 1'b1;
					f_code  = ERR_UNI_CUT;
				end else if (!hv[4]) begin
					do_fail = 1'b1;
					f_code  = ERR_BAD_HEX;
				end else if (cnt_q == 2'd3) begin
					cnt_n = '0;
					acc_n = '0;
					if (hi_sur) begin
						held_n  = acc_sh;
						phase_n = PH_HIGH;
					end else begin
						u_en    = 1'b1;
						u_cp    = {5'd0, acc_sh};
						phase_n = PH_STR;
					end
				end else begin
					acc_n = acc_sh;
					cnt_n = cnt_q + 2'd1;
				end
			end
			PH_HIGH: begin
				if (is_bs) begin
					phase_n = PH_HIGH_BS;
				end else begin
					// lone high surrogate goes out as three bytes
					u_en    = 1'b1;
					u_cp    = {5'd0, held_q};
					held_n  = '0;
					phase_n = PH_STR;
					if (mode) begin
						do_fail = 1'b1;
						f_code  = ERR_UNTERM;
					end else begin
						do_str = 1'b1;
					end
				end
			end
			PH_HIGH_BS: begin
				if (is_u) begin
					phase_n = PH_LOW;
					acc_n   = '0;
					cnt_n   = '0;
				end else begin
					u_en    = 1'b1;
					u_cp    = {5'd0, held_q};
					held_n  = '0;
					phase_n = PH_ESC;
					if (mode) begin
						do_fail = 1'b1;
						f_code  = ERR_ESC_CUT;
					end else begin
						do_esc = 1'b1;
					end
				end
			end
			PH_LOW: begin
				if (mode) begin
					do_fail = 1'b1;
					f_code  = ERR_UNI_CUT;
				end else if (!hv[4]) begin
					do_fail = 1'b1;
					f_code  = ERR_BAD_HEX;
				end else if (cnt_q == 2'd3) begin
					// partner out of range: the high half alone is sent
					u_en    = 1'b1;
					u_cp    = lo_sur ? pair_cp : {5'd0, held_q};
					acc_n   = '0;
					cnt_n   = '0;
					held_n  = '0;
					phase_n = PH_STR;
				end else begin
					acc_n = acc_sh;
					cnt_n = cnt_q + 2'd1;
				end
			end
			default: begin
				phase_n = PH_SKIP;
			end
		endcase

		// Ordinary string byte
		if (do_str) begin
			if (text_byte == CH_QUOTE) begin
				t_en    = 1'b1;
				t_kind  = KIND_CLOSE;
				phase_n = PH_IDLE;
				acc_n   = '0;
				cnt_n   = '0;
				held_n  = '0;
			end else if (text_byte == CH_BSLASH) begin
				phase_n = PH_ESC;
			end else begin
				t_en   = 1'b1;
				t_data = text_byte;
			end
		end

		// Escape letter
		if (do_esc) begin
			if (em[8]) begin
				t_en    = 1'b1;
				t_data  = em[7:0];
				phase_n = PH_STR;
			end else if (text_byte == CH_U) begin
				phase_n = PH_HEX;
				acc_n   = '0;
				cnt_n   = '0;
			end else begin
				do_fail = 1'b1;
				f_code  = ERR_UNKNOWN_ESC;
			end
		end

		// Error ends the string
		if (do_fail) begin
			t_en    = 1'b1;
			t_kind  = KIND_ERR;
			t_data  = '0;
			t_code  = f_code;
			phase_n = PH_SKIP;
			acc_n   = '0;
			cnt_n   = '0;
			held_n  = '0;
		end
	end

	// Burst assembly: UTF-8 bytes first, then the single tail result
	assign enc   = utf8_encode(u_cp);
	assign u_len = u_en ? enc.len : 3'd0;

	always_comb begin
		burst.cnt = u_len + {2'd0, t_en};
		for (int i = 0; i < MAX_RES; i++) begin
			if (3'(i) < u_len) begin
				burst.r[i] = '{kind: KIND_BYTE, data: enc.b[i], code: 3'd0};
			end else begin
				burst.r[i] = '{kind: t_kind, data: t_data, code: t_code};
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			held_q  <= held_n;
		end
	end

endmodule

// ===== rtl/core/jsu_burst_buf.sv =====
// ----------------------------------------------------------------------------
// jsu_burst_buf
// Result register: holds the results of one transaction and sends them out
// one per cycle while m_tready is high; frees itself in the cycle its last result is taken.
// ----------------------------------------------------------------------------
module jsu_burst_buf import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,      // take a new burst
	input  burst_t      burst,
	output logic        free,      // a new burst may be loaded this cycle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	output logic        m_tlast
);

	res_t [MAX_RES-1:0] ent_q;
	logic [2:0]         rem_q;
	logic [1:0]         idx_q;
	res_t               cur;
	logic               take;

	assign cur      = ent_q[idx_q];
	assign m_tvalid = (rem_q != 3'd0);
	assign m_tlast  = (rem_q == 3'd1);
	assign m_tdata  = {5'd0, cur.code, cur.data};
	assign m_tuser  = cur.kind;
	assign take     = m_tvalid && m_tready;
	assign free     = (rem_q == 3'd0) || (m_tlast && m_tready);

	// Payload entries
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= burst.r;
		end
	end

	// Read pointer and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= burst.cnt;
			idx_q <= '0;
		end else if (take) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/core/json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for a quoted JSON string: simple escapes, \uXXXX to
// UTF-8 with surrogate pairing, closing marker or first error per string.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata                          tuser         tlast
// s_*       in   [7:0] text_byte                [0] mode      -
// m_*       out  [7:0] out_byte, [10:8] code    [1:0] kind    last result
//
// An accepted byte waits in the input register until the result register
// is free, then is decoded and its results (0 to 4) are loaded into it.
// Sustained rate is one byte per cycle while each byte gives at most one
// result and m_tready stays high; a byte giving more results holds the
// input side while the single output port drains the result register.
// Reset clears the string state (waiting for an opening quote) and both
// valid flags; result payload is not reset.
// ----------------------------------------------------------------------------
module json_string_unescape import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	output logic        m_tlast
);

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       free;
	logic       advance;
	burst_t     burst;

	assign advance  = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// Decode and string state
	jsu_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.mode      (mode_s1),
		.text_byte (byte_s1),
		.burst     (burst)
	);

	// Result register and output drain
	jsu_burst_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.burst    (burst),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/core/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the result stream of json_string_unescape.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// Stalled result transaction holds
	`JSU_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
	// Closing marker and error are always the final result of their item
	`JSU_ASSERT(a_end_last, clk, arst_n, m_tvalid && m_tuser != KIND_BYTE |-> m_tlast, "close or error not last")
	// Error code only on error results
	`JSU_ASSERT(a_code_zero, clk, arst_n, m_tvalid && m_tuser != KIND_ERR |-> m_tdata[10:8] == 3'd0, "error code outside error")
	// Error results carry no byte and a known code
	`JSU_ASSERT(a_err_form, clk, arst_n, m_tvalid && m_tuser == KIND_ERR |-> m_tdata[7:0] == 8'd0 && m_tdata[10:8] <= ERR_UNKNOWN_ESC, "malformed error")
	// Nothing pending on the result side when reset is released
	`JSU_ASSERT_ALWAYS(a_rst_idle, clk, $rose(arst_n) |-> !m_tvalid, "result at reset release")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);
